[hdl/dtbb_pkg.sv]
// -----------------------------------------------------------------------------
// dtbb_pkg: shared constants and types for the dual-tone biquad cascade
// Widths, the coefficient literal tables and the Q-format conversion.
// -----------------------------------------------------------------------------
package dtbb_pkg;

   // Field and datapath widths
   localparam int unsigned SAMPLE_W  = 16;
   localparam int unsigned DW        = 32;   // section value width
   localparam int unsigned CW        = 32;   // coefficient width at the multiplier
   localparam int unsigned PW        = 64;   // product width
   localparam int unsigned XS_W      = 35;   // x +/- 2*x1 + x2 before scaling
   localparam int unsigned ACC_W     = 56;   // wide section sum
   localparam int unsigned NUM_SEC   = 4;    // sections per bank
   localparam int unsigned NUM_STAGE = 8;    // sections over both banks
   localparam int unsigned IDX_W     = 3;    // {bank, section}

   // Literals are in units of 1e-8
   localparam logic signed [63:0] LIT_SCALE = 64'sd100000000;

   typedef logic signed [CW-1:0] coef_tab_type [NUM_STAGE];

   // Stage order: upper bank sections 0..3, then lower bank sections 0..3
   localparam coef_tab_type A1_LIT = '{
      -32'sd177495574, -32'sd178072480, -32'sd177882789, -32'sd179257281,
      -32'sd184602348, -32'sd184997046, -32'sd185002393, -32'sd185937390
   };
   localparam coef_tab_type A2_LIT = '{
      32'sd98471132, 32'sd98490396, 32'sd99358215, 32'sd99377646,
      32'sd98747166, 32'sd98763379, 32'sd99474384, 32'sd99490711
   };
   localparam coef_tab_type GAIN_LIT = '{
      32'sd303500, 32'sd295500, 32'sd2263000, 32'sd2271000,
      32'sd201900, 32'sd196400, 32'sd2280000, 32'sd2294000
   };

   // Scale literals by 2^frac and truncate toward zero (elaboration only)
   function automatic coef_tab_type qtab(coef_tab_type lits, int unsigned frac);
      coef_tab_type      q;
      logic signed [63:0] w;
      for (int i = 0; i < NUM_STAGE; i++) begin
         w    = 64'(lits[i]) <<< frac;
         q[i] = CW'(w / LIT_SCALE);
      end
      return q;
   endfunction

endpackage

[hdl/dtbb_if.sv]
// -----------------------------------------------------------------------------
// dtbb_if: sample and result channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// -----------------------------------------------------------------------------
interface dtbb_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [dtbb_pkg::SAMPLE_W-1:0]   sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface dtbb_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [dtbb_pkg::DW-1:0]   upper_band;
   logic signed [dtbb_pkg::DW-1:0]   lower_band;

   modport source (output valid, output upper_band, output lower_band, input ready);
   modport sink   (input valid, input upper_band, input lower_band, output ready);
endinterface

[hdl/dtbb_mul.sv]
// -----------------------------------------------------------------------------
// dtbb_mul: shared signed multiplier
// One 32x32 signed multiply per cycle; the product register holds when idle.
// -----------------------------------------------------------------------------
module dtbb_mul (
   input  logic                              clock,
   input  logic                              mul_en,
   input  logic signed [dtbb_pkg::CW-1:0]    mul_a,
   input  logic signed [dtbb_pkg::DW-1:0]    mul_b,
   output logic signed [dtbb_pkg::PW-1:0]    prod_ff
);

   logic signed [dtbb_pkg::PW-1:0] prod_in;

   // product next value
   always_comb begin
      prod_in = prod_ff;
      if (mul_en) begin
         prod_in = dtbb_pkg::PW'(mul_a) * dtbb_pkg::PW'(mul_b);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

[hdl/dual_tone_bandpass_biquad_cascade_unit.sv]
// Eight sections run one after another through one shared multiplier; each
// section steps through FB1, FB2, SUM and GAIN, then a finish state follows.
// A sample is taken only in idle. A stalled result holds the next result in
// the finish state, and so holds off the sample after that one.
// Reset (synchronous, active high) clears the filter history and the result
// valid flag and returns the sequencer to idle.
// -----------------------------------------------------------------------------
// dual_tone_bandpass_biquad_cascade_unit: two 4-section biquad bandpass banks
// Direct-form-I sections with gain scaling, sequenced over a shared multiplier.
// -----------------------------------------------------------------------------
module dual_tone_bandpass_biquad_cascade_unit #(
   parameter int unsigned FRAC_BITS = 14
) (
   input  logic            clock,
   input  logic            reset,
   dtbb_req_if.sink        req_chan,
   dtbb_rsp_if.source      rsp_chan
);

   localparam int unsigned DW    = dtbb_pkg::DW;
   localparam int unsigned XS_W  = dtbb_pkg::XS_W;
   localparam int unsigned ACC_W = dtbb_pkg::ACC_W;
   localparam int unsigned IDX_W = dtbb_pkg::IDX_W;
   localparam int unsigned NSTG  = dtbb_pkg::NUM_STAGE;

   // Q(FRAC_BITS) coefficient tables
   localparam dtbb_pkg::coef_tab_type A1_Q   =
      dtbb_pkg::qtab(dtbb_pkg::A1_LIT, FRAC_BITS);
   localparam dtbb_pkg::coef_tab_type A2_Q   =
      dtbb_pkg::qtab(dtbb_pkg::A2_LIT, FRAC_BITS);
   localparam dtbb_pkg::coef_tab_type GAIN_Q =
      dtbb_pkg::qtab(dtbb_pkg::GAIN_LIT, FRAC_BITS);

   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NSTG - 1);
   localparam logic [IDX_W-1:0] LOWER_IDX = IDX_W'(dtbb_pkg::NUM_SEC);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FB1,      // x terms, a1*y[n-1]
      ST_FB2,      // scale x terms, a2*y[n-2]
      ST_SUM,      // section value
      ST_GAIN,     // y*gain
      ST_FINISH
   } state_type;

   state_type                       state_ff, state_in;
   logic [IDX_W-1:0]                idx_ff, idx_in;
   logic signed [dtbb_pkg::SAMPLE_W-1:0] sample_ff, sample_in;
   logic signed [XS_W-1:0]          xs_ff, xs_in;
   logic signed [ACC_W-1:0]         acc_ff, acc_in;
   logic signed [DW-1:0]            y_ff, y_in;
   logic signed [DW-1:0]            upper_ff, upper_in;
   logic signed [DW-1:0]            x1_ff [NSTG];
   logic signed [DW-1:0]            x2_ff [NSTG];
   logic signed [DW-1:0]            y1_ff [NSTG];
   logic signed [DW-1:0]            y2_ff [NSTG];
   logic signed [DW-1:0]            x1_in [NSTG];
   logic signed [DW-1:0]            x2_in [NSTG];
   logic signed [DW-1:0]            y1_in [NSTG];
   logic signed [DW-1:0]            y2_in [NSTG];
   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0]            rsp_upper_ff, rsp_upper_in;
   logic signed [DW-1:0]            rsp_lower_ff, rsp_lower_in;

   // shared multiplier
   logic                            mul_en;
   logic signed [dtbb_pkg::CW-1:0]  mul_a;
   logic signed [DW-1:0]            mul_b;
   logic signed [dtbb_pkg::PW-1:0]  prod_ff;

   logic signed [DW-1:0]            x_cur;
   logic signed [DW-1:0]            prod_scaled;
   logic signed [XS_W-1:0]          x1_twice;
   logic signed [ACC_W-1:0]         acc_sum;

   dtbb_mul u_mul (
      .clock   (clock),
      .mul_en  (mul_en),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   assign req_chan.ready      = (state_ff == ST_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.upper_band = rsp_upper_ff;
   assign rsp_chan.lower_band = rsp_lower_ff;

   // gain-scaled value of the previous section: floor shift, wrap to 32 bits
   assign prod_scaled = prod_ff[FRAC_BITS +: DW];

   // section input: the sample at the head of each bank, else the previous section's scaled output
   assign x_cur = (idx_ff[1:0] == 2'd0) ? DW'(sample_ff) : prod_scaled;

   assign x1_twice = XS_W'(x1_ff[idx_ff]) <<< 1;

   // wide section sum less the second feedback product
   assign acc_sum = acc_ff - prod_ff[ACC_W-1:0];

   // multiplier operand selection
   always_comb begin
      mul_en = 1'b0;
      mul_a  = A1_Q[idx_ff];
      mul_b  = y1_ff[idx_ff];
      case (state_ff)
         ST_FB1: begin
            mul_en = 1'b1;
         end
         ST_FB2: begin
            mul_en = 1'b1;
            mul_a  = A2_Q[idx_ff];
            mul_b  = y2_ff[idx_ff];
         end
         ST_GAIN: begin
            mul_en = 1'b1;
            mul_a  = GAIN_Q[idx_ff];
            mul_b  = y_ff;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   // sequencer next state and datapath
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      sample_in    = sample_ff;
      xs_in        = xs_ff;
      acc_in       = acc_ff;
      y_in         = y_ff;
      upper_in     = upper_ff;
      x1_in        = x1_ff;
      x2_in        = x2_ff;
      y1_in        = y1_ff;
      y2_in        = y2_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_upper_in = rsp_upper_ff;
      rsp_lower_in = rsp_lower_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               sample_in = req_chan.sample;
               idx_in    = '0;
               state_in  = ST_FB1;
            end
         end
         ST_FB1: begin
            // sections 0,1 of each bank use b1 = +2, sections 2,3 use b1 = -2
            if (idx_ff[1] == 1'b0) begin
               xs_in = XS_W'(x_cur) + x1_twice + XS_W'(x2_ff[idx_ff]);
            end else begin
               xs_in = XS_W'(x_cur) - x1_twice + XS_W'(x2_ff[idx_ff]);
            end
            x2_in[idx_ff] = x1_ff[idx_ff];
            x1_in[idx_ff] = x_cur;
            if (idx_ff == LOWER_IDX) begin
               upper_in = prod_scaled;
            end
            state_in = ST_FB2;
         end
         ST_FB2: begin
            acc_in   = (ACC_W'(xs_ff) <<< FRAC_BITS) - prod_ff[ACC_W-1:0];
            state_in = ST_SUM;
         end
         ST_SUM: begin
            y_in          = acc_sum[FRAC_BITS +: DW];
            y2_in[idx_ff] = y1_ff[idx_ff];
            y1_in[idx_ff] = acc_sum[FRAC_BITS +: DW];
            state_in      = ST_GAIN;
         end
         ST_GAIN: begin
            if (idx_ff == LAST_IDX) begin
               state_in = ST_FINISH;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_FB1;
            end
         end
         ST_FINISH: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_upper_in = upper_ff;
               rsp_lower_in = prod_scaled;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state, history and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NSTG; i++) begin
            x1_ff[i] <= '0;
            x2_ff[i] <= '0;
            y1_ff[i] <= '0;
            y2_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         x1_ff        <= x1_in;
         x2_ff        <= x2_in;
         y1_ff        <= y1_in;
         y2_ff        <= y2_in;
      end
      sample_ff    <= sample_in;
      xs_ff        <= xs_in;
      acc_ff       <= acc_in;
      y_ff         <= y_in;
      upper_ff     <= upper_in;
      rsp_upper_ff <= rsp_upper_in;
      rsp_lower_ff <= rsp_lower_in;
   end

endmodule
